### design/ptns_pkg.sv
// Package: shared types and constants of the PWM tone note sequencer.
package ptns_pkg;

    localparam int ACTION_W   = 2;
    localparam int INDEX_W    = 6;
    localparam int FREQ_W     = 16;
    localparam int DUR_W      = 16;
    localparam int CLK_W      = 27;
    localparam int LEN_W      = 7;
    localparam int SHIFT_W    = 4;
    localparam int SCALE_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;
    localparam int ENTRY_W    = FREQ_W + DUR_W;
    localparam int PROD_W     = DUR_W + SCALE_W;
    localparam int DIV_STEPS  = CLK_W;
    localparam int DIV_CNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PLAY    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SONG_LENGTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_CLOCK_HZ = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_SHIFT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE_ENABLE = 3'd4;

    localparam logic [LEN_W-1:0]   RST_SONG_LENGTH    = 7'd1;
    localparam logic [CLK_W-1:0]   RST_TIMER_CLOCK_HZ = 27'd1000000;
    localparam logic [SHIFT_W-1:0] RST_DUTY_SHIFT     = 4'd3;
    localparam logic [SCALE_W-1:0] RST_DURATION_SCALE = 12'd256;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wr_note;
        logic restart;
        logic play_start;
        logic note_load;
        logic div_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic is_rest;
        logic div_last;
        logic out_free;
    } t_dp_stat;

endpackage

### design/ptns_if.sv
// Interfaces: note item input, result output and configuration write channels.
interface ptns_in_if;
    import ptns_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  entry_index;
    logic [FREQ_W-1:0]   entry_freq;
    logic [DUR_W-1:0]    entry_duration;
    modport source (output valid, action, entry_index, entry_freq, entry_duration,
                    input ready);
    modport sink (input valid, action, entry_index, entry_freq, entry_duration,
                  output ready);
endinterface

interface ptns_out_if;
    import ptns_pkg::*;
    logic               valid;
    logic               ready;
    logic [CLK_W-1:0]   period_reload;
    logic [CLK_W-1:0]   compare_value;
    logic [DUR_W-1:0]   note_time_ms;
    logic               is_rest;
    logic [INDEX_W-1:0] played_index;
    modport source (output valid, period_reload, compare_value, note_time_ms, is_rest,
                    played_index, input ready);
    modport sink (input valid, period_reload, compare_value, note_time_ms, is_rest,
                  played_index, output ready);
endinterface

interface ptns_cfg_if;
    import ptns_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### design/pwm_tone_note_sequencer.sv
// Top level: PWM tone note sequencer, controller plus datapath.
//
// Channels: i_note takes items (action, entry_index, entry_freq, entry_duration).
// A write item loads one note entry, a restart item sets the note pointer to 0,
// a play item reads the note at the pointer and returns one result transfer on
// o_result (period_reload, compare_value, note_time_ms, is_rest, played_index).
// i_cfg writes the five registers by index; it is always ready.
// Write and restart take effect on their transfer edge. A tone play reads the
// memory on its transfer edge, then passes the load state, the 27 steps of the
// restoring divider and the finish state, where its result is loaded. A rest
// skips the divider and goes from the load state straight to the finish state.
// Throughput: the one-bit-per-cycle divider sets the tone play rate; no item is
// taken while a play is under way, else write and restart items go one per cycle.
// Reset (synchronous, active low) restores register defaults, clears the
// pointer, the held period and the result valid; note memory is undefined
// until written.
// A stalled receiver: the result register holds; the next item is still taken,
// and a new play result waits in the finish state until the register frees.
module pwm_tone_note_sequencer #(
    parameter int NOTE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptns_in_if.sink     i_note,
    ptns_cfg_if.sink    i_cfg,
    ptns_out_if.source  o_result
);
    import ptns_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencing of items
    ptns_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_note.valid),
        .i_action   (i_note.action),
        .o_in_ready (i_note.ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    // storage, divider, scaler and result register
    ptns_datapath #(
        .NOTE_DEPTH (NOTE_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_entry_index    (i_note.entry_index),
        .i_entry_freq     (i_note.entry_freq),
        .i_entry_duration (i_note.entry_duration),
        .i_cfg            (i_cfg),
        .o_result         (o_result)
    );

endmodule

### design/ptns_ctrl.sv
// Controller: sequences write, restart and play items through the datapath.
module ptns_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [ptns_pkg::ACTION_W-1:0] i_action,
    output logic                      o_in_ready,
    output ptns_pkg::t_dp_cmd         o_cmd,
    input  ptns_pkg::t_dp_stat        i_stat
);
    import ptns_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_action == ACT_PLAY)) n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = i_stat.is_rest ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.wr_note    = w_accept && (i_action == ACT_WRITE);
                o_cmd.restart    = w_accept && (i_action == ACT_RESTART);
                o_cmd.play_start = w_accept && (i_action == ACT_PLAY);
            end
            S_LOAD: begin
                o_cmd.note_load = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_DONE: begin
                o_cmd.finish = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### design/ptns_datapath.sv
// Datapath: config registers, note memory, pointer, divider, scaler, result register.
module ptns_datapath #(
    parameter int NOTE_DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ptns_pkg::t_dp_cmd           i_cmd,
    output ptns_pkg::t_dp_stat          o_stat,
    input  logic [ptns_pkg::INDEX_W-1:0] i_entry_index,
    input  logic [ptns_pkg::FREQ_W-1:0]  i_entry_freq,
    input  logic [ptns_pkg::DUR_W-1:0]   i_entry_duration,
    ptns_cfg_if.sink                    i_cfg,
    ptns_out_if.source                  o_result
);
    import ptns_pkg::*;

    localparam int ADDR_W = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
    localparam int PTR_W  = $clog2(NOTE_DEPTH + 1);
    localparam int CMP_W  = (PTR_W > LEN_W) ? PTR_W : LEN_W;

    // configuration registers
    logic [LEN_W-1:0]   r_song_length;
    logic [CLK_W-1:0]   r_timer_hz;
    logic [SHIFT_W-1:0] r_duty_shift;
    logic [SCALE_W-1:0] r_dur_scale;
    logic               r_adv;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_song_length <= RST_SONG_LENGTH;
            r_timer_hz    <= RST_TIMER_CLOCK_HZ;
            r_duty_shift  <= RST_DUTY_SHIFT;
            r_dur_scale   <= RST_DURATION_SCALE;
            r_adv         <= 1'b1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SONG_LENGTH:    r_song_length <= i_cfg.data[LEN_W-1:0];
                CFG_TIMER_CLOCK_HZ: r_timer_hz    <= i_cfg.data[CLK_W-1:0];
                CFG_DUTY_SHIFT:     r_duty_shift  <= i_cfg.data[SHIFT_W-1:0];
                CFG_DURATION_SCALE: r_dur_scale   <= i_cfg.data[SCALE_W-1:0];
                CFG_ADVANCE_ENABLE: r_adv         <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // note memory, one write port and one registered read port
    logic [ENTRY_W-1:0] r_mem [NOTE_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;
    logic [15:0]        w_idx_ext;
    logic               w_idx_ok;

    assign w_idx_ext = {{(16-INDEX_W){1'b0}}, i_entry_index};
    assign w_idx_ok  = 32'(w_idx_ext) < 32'(NOTE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_note && w_idx_ok) begin
            r_mem[w_idx_ext[ADDR_W-1:0]] <= {i_entry_duration, i_entry_freq};
        end
    end

    // pointer with wrap at the effective song length
    logic [PTR_W-1:0] r_ptr;
    logic [PTR_W-1:0] r_play_ptr;
    logic [CMP_W-1:0] w_len;
    logic [PTR_W-1:0] w_ptr_eff;
    logic [15:0]      w_ptr_ext;

    always_comb begin
        w_len = CMP_W'(r_song_length);
        if (w_len == '0) w_len = CMP_W'(1);
        if (w_len > CMP_W'(NOTE_DEPTH)) w_len = CMP_W'(NOTE_DEPTH);
    end

    assign w_ptr_eff = (CMP_W'(r_ptr) >= w_len) ? '0 : r_ptr;
    assign w_ptr_ext = 16'(w_ptr_eff);

    always_ff @(posedge i_clk) begin
        if (i_cmd.play_start) begin
            r_rd_data <= r_mem[w_ptr_ext[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.play_start) r_play_ptr <= w_ptr_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_cmd.restart) begin
            r_ptr <= '0;
        end else if (i_cmd.finish) begin
            r_ptr <= r_adv ? (r_play_ptr + PTR_W'(1)) : r_play_ptr;
        end
    end

    // restoring divider, one quotient bit per cycle; tempo product
    logic [FREQ_W-1:0]    w_freq;
    logic [FREQ_W-1:0]    r_rem;
    logic [CLK_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PROD_W-1:0]    r_prod;
    logic [FREQ_W:0]      w_trial;
    logic [FREQ_W:0]      w_diff;

    assign w_freq  = r_rd_data[FREQ_W-1:0];
    assign w_trial = {r_rem, r_quo[CLK_W-1]};
    assign w_diff  = w_trial - {1'b0, w_freq};

    always_ff @(posedge i_clk) begin
        if (i_cmd.note_load) begin
            r_rem  <= '0;
            r_quo  <= r_timer_hz;
            r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            r_prod <= PROD_W'(r_rd_data[ENTRY_W-1:FREQ_W]) * PROD_W'(r_dur_scale);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            if (!w_diff[FREQ_W]) begin
                r_rem <= w_diff[FREQ_W-1:0];
                r_quo <= {r_quo[CLK_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[FREQ_W-1:0];
                r_quo <= {r_quo[CLK_W-2:0], 1'b0};
            end
        end
    end

    // result forming
    logic             w_rest;
    logic [CLK_W-1:0] w_period;
    logic [CLK_W-1:0] w_compare;
    logic [DUR_W-1:0] w_scaled;
    logic [CLK_W-1:0] r_held;
    logic             r_out_valid;

    assign w_rest    = (w_freq == '0);
    assign w_period  = (r_quo == '0) ? '0 : (r_quo - CLK_W'(1));
    assign w_compare = w_period >> r_duty_shift;
    assign w_scaled  = (r_prod[PROD_W-1:DUR_W+8] != '0) ? '1 : r_prod[DUR_W+7:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_cmd.finish && !w_rest) begin
            r_held <= w_period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_result.period_reload <= w_rest ? r_held : w_period;
            o_result.compare_value <= w_rest ? '0 : w_compare;
            o_result.note_time_ms  <= w_scaled;
            o_result.is_rest       <= w_rest;
            o_result.played_index  <= INDEX_W'(r_play_ptr);
        end
    end

    assign o_result.valid = r_out_valid;

    assign o_stat.is_rest  = w_rest;
    assign o_stat.div_last = (r_cnt == '0);
    assign o_stat.out_free = !r_out_valid || o_result.ready;

endmodule

### sim/ptns_checker.sv
// Checker: watches the note, config and result channels, predicts each tone and compares.
`timescale 1ns / 100ps

module ptns_checker #(
    parameter int NOTE_SLOTS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ptns_in_if   i_note,
    ptns_cfg_if  i_cfg,
    ptns_out_if  i_result,
    output int   o_fail_count,
    output int   o_pending
);
    import ptns_pkg::*;

    typedef struct packed {
        logic [CLK_W-1:0]   period;
        logic [CLK_W-1:0]   compare;
        logic [DUR_W-1:0]   time_ms;
        logic               is_rest;
        logic [INDEX_W-1:0] index;
    } t_tone;

    logic [FREQ_W-1:0]  mem_freq [NOTE_SLOTS];
    logic [DUR_W-1:0]   mem_dur  [NOTE_SLOTS];
    logic [LEN_W-1:0]   note_ptr;
    logic [CLK_W-1:0]   held_period;
    logic [LEN_W-1:0]   song_len;
    logic [CLK_W-1:0]   tick_hz;
    logic [SHIFT_W-1:0] duty_shift;
    logic [SCALE_W-1:0] tempo_scale;
    logic               advance_on;
    t_tone              expected_tones[$];
    int                 fail_count = 0;

    // Tone for the note at the pointer; wraps the pointer and advances it when advance is on.
    function automatic t_tone predict_tone();
        t_tone             tone;
        int unsigned       play_len;
        logic [CLK_W-1:0]  quotient;
        logic [PROD_W-1:0] product;
        logic [FREQ_W-1:0] freq;
        play_len = (song_len == 0) ? 1 : ((song_len > NOTE_SLOTS) ? NOTE_SLOTS : song_len);
        if (note_ptr >= play_len) begin
            note_ptr = '0;
        end
        freq = mem_freq[note_ptr];
        if (freq == 0) begin
            tone.is_rest = 1'b1;
            tone.period  = held_period;
            tone.compare = '0;
        end else begin
            quotient     = tick_hz / CLK_W'(freq);
            tone.is_rest = 1'b0;
            tone.period  = (quotient == 0) ? '0 : quotient - 1'b1;
            tone.compare = tone.period >> duty_shift;
            held_period  = tone.period;
        end
        product = PROD_W'(mem_dur[note_ptr]) * PROD_W'(tempo_scale);
        tone.time_ms = (product[PROD_W-1:DUR_W+8] != '0) ? 16'hFFFF : product[DUR_W+7:8];
        tone.index   = note_ptr[INDEX_W-1:0];
        if (advance_on) begin
            note_ptr = note_ptr + 1'b1;
        end
        return tone;
    endfunction

    task automatic check_field(input string field, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_tone want;
        if (!i_rst_n) begin
            for (int i = 0; i < NOTE_SLOTS; i++) begin
                mem_freq[i] = '0;
                mem_dur[i]  = '0;
            end
            note_ptr    = '0;
            held_period = '0;
            song_len    = RST_SONG_LENGTH;
            tick_hz     = RST_TIMER_CLOCK_HZ;
            duty_shift  = RST_DUTY_SHIFT;
            tempo_scale = RST_DURATION_SCALE;
            advance_on  = 1'b1;
            expected_tones.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                if (expected_tones.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual period %0d",
                             $time, i_result.period_reload);
                    fail_count++;
                end else begin
                    want = expected_tones.pop_front();
                    check_field("period_reload", 64'(want.period),
                                64'(i_result.period_reload));
                    check_field("compare_value", 64'(want.compare),
                                64'(i_result.compare_value));
                    check_field("note_time_ms", 64'(want.time_ms),
                                64'(i_result.note_time_ms));
                    check_field("is_rest", 64'(want.is_rest), 64'(i_result.is_rest));
                    check_field("played_index", 64'(want.index),
                                64'(i_result.played_index));
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_SONG_LENGTH:    song_len    = i_cfg.data[LEN_W-1:0];
                    CFG_TIMER_CLOCK_HZ: tick_hz     = i_cfg.data[CLK_W-1:0];
                    CFG_DUTY_SHIFT:     duty_shift  = i_cfg.data[SHIFT_W-1:0];
                    CFG_DURATION_SCALE: tempo_scale = i_cfg.data[SCALE_W-1:0];
                    CFG_ADVANCE_ENABLE: advance_on  = i_cfg.data[0];
                    default: ;
                endcase
            end
            if (i_note.valid && i_note.ready) begin
                case (i_note.action)
                    ACT_WRITE: begin
                        if (i_note.entry_index < NOTE_SLOTS) begin
                            mem_freq[i_note.entry_index] = i_note.entry_freq;
                            mem_dur[i_note.entry_index]  = i_note.entry_duration;
                        end
                    end
                    ACT_RESTART: note_ptr = '0;
                    ACT_PLAY:    expected_tones.push_back(predict_tone());
                    default: ;
                endcase
            end
        end
        o_fail_count = fail_count;
        o_pending    = expected_tones.size();
    end

endmodule

### sim/tb_top.sv
// Testbench top: clock, reset, note and config stimulus, result back-pressure, verdict.
`timescale 1ns / 100ps

module tb_top;
    import ptns_pkg::*;

    localparam int NOTE_DEPTH      = 64;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 115;
    // Long enough for a tone play plus any trailing write or restart.
    localparam int SETTLE_CYCLES   = 40;
    // Receiver hold-off in the pressure phase: many play times, so the block backs up.
    localparam int HOLD_CYCLES     = 600;
    // Action code with no meaning; the block must swallow it without a result.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic burst_mode;   // sender offers back to back, no gaps
    logic hold_req;     // asks the receiver process for one long hold-off
    int   fail_count;
    int   pending_tones;

    ptns_in_if  note_bus ();
    ptns_cfg_if cfg_bus ();
    ptns_out_if result_bus ();

    always #5 i_clk = ~i_clk;

    pwm_tone_note_sequencer #(
        .NOTE_DEPTH (NOTE_DEPTH)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_note   (note_bus),
        .i_cfg    (cfg_bus),
        .o_result (result_bus)
    );

    ptns_checker #(
        .NOTE_SLOTS (NOTE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_note       (note_bus),
        .i_cfg        (cfg_bus),
        .i_result     (result_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending_tones)
    );

    // Sender gap after each transfer: mostly none or short, now and then long.
    function automatic int pick_gap();
        int p;
        if (burst_mode) begin
            return 0;
        end
        p = $urandom_range(99);
        if (p < 55) begin
            return 0;
        end
        if (p < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Frequencies lean toward rests, the extremes and the audible range.
    function automatic logic [FREQ_W-1:0] rand_freq();
        int p;
        p = $urandom_range(99);
        if (p < 12) begin
            return '0;
        end
        if (p < 17) begin
            return 16'hFFFF;
        end
        if (p < 22) begin
            return 16'd1;
        end
        if (p < 50) begin
            return FREQ_W'($urandom_range(20, 5000));
        end
        return FREQ_W'($urandom);
    endfunction

    function automatic logic [DUR_W-1:0] rand_dur();
        int p;
        p = $urandom_range(99);
        if (p < 8) begin
            return '0;
        end
        if (p < 14) begin
            return 16'hFFFF;
        end
        if (p < 50) begin
            return DUR_W'($urandom_range(1, 2000));
        end
        return DUR_W'($urandom);
    endfunction

    // One note-channel transfer. Valid stays high into the next call when no gap
    // is drawn, so back-to-back items never drop valid in between.
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [INDEX_W-1:0] idx,
                             input logic [FREQ_W-1:0] freq, input logic [DUR_W-1:0] dur);
        int gap;
        @(negedge i_clk);
        note_bus.valid          = 1'b1;
        note_bus.action         = act;
        note_bus.entry_index    = idx;
        note_bus.entry_freq     = freq;
        note_bus.entry_duration = dur;
        do @(posedge i_clk); while (!note_bus.ready);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            note_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic set_config(input logic [LEN_W-1:0] len, input logic [CLK_W-1:0] hz,
                              input logic [SHIFT_W-1:0] shift, input logic [SCALE_W-1:0] scale,
                              input logic adv);
        write_reg(CFG_SONG_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_TIMER_CLOCK_HZ, CFG_DATA_W'(hz));
        write_reg(CFG_DUTY_SHIFT, CFG_DATA_W'(shift));
        write_reg(CFG_DURATION_SCALE, CFG_DATA_W'(scale));
        write_reg(CFG_ADVANCE_ENABLE, CFG_DATA_W'(adv));
    endtask

    // Mostly legal lengths; sometimes 0 or past the memory depth. Low clock rates
    // now and then so the period underflows for high notes.
    task automatic random_config();
        logic [LEN_W-1:0] len;
        logic [CLK_W-1:0] hz;
        len = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(127))
                                       : LEN_W'($urandom_range(1, NOTE_DEPTH));
        hz  = ($urandom_range(4) == 0) ? CLK_W'($urandom_range(1, 70000))
                                       : CLK_W'($urandom_range(1, 100_000_000));
        set_config(len, hz, SHIFT_W'($urandom_range(15)), SCALE_W'($urandom_range(4095)),
                   $urandom_range(9) != 0);
    endtask

    // Plays dominate; writes change the song under way, restarts and dead codes mixed in.
    // Fields a play or restart ignores still get random bits.
    task automatic send_random();
        int                p;
        logic [INDEX_W-1:0] idx;
        logic [FREQ_W-1:0]  freq;
        logic [DUR_W-1:0]   dur;
        p    = $urandom_range(99);
        idx  = INDEX_W'($urandom);
        freq = FREQ_W'($urandom);
        dur  = DUR_W'($urandom);
        if (p < (burst_mode ? 85 : 60)) begin
            send_item(ACT_PLAY, idx, freq, dur);
        end else if (p < 87) begin
            send_item(ACT_WRITE, idx, rand_freq(), rand_dur());
        end else if (p < 95) begin
            send_item(ACT_RESTART, idx, freq, dur);
        end else begin
            send_item(ACT_UNUSED, idx, freq, dur);
        end
    endtask

    // Drop valid, wait for every tone still owed, then let a trailing
    // write or restart finish before the registers may change.
    task automatic settle();
        @(negedge i_clk);
        note_bus.valid = 1'b0;
        while (pending_tones != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Result back-pressure: ready bursts of varying length, short drops,
    // occasional long drops, and one long hold-off on request.
    initial begin
        int run;
        int p;
        result_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                result_bus.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            p = $urandom_range(99);
            if (p < 60) begin
                result_bus.ready = 1'b1;
                run = $urandom_range(1, 24);
            end else if (p < 92) begin
                result_bus.ready = 1'b0;
                run = $urandom_range(1, 3);
            end else begin
                result_bus.ready = 1'b0;
                run = $urandom_range(10, 40);
            end
            repeat (run - 1) @(negedge i_clk);
        end
    end

    initial begin
        i_rst_n                 = 1'b0;
        burst_mode              = 1'b0;
        hold_req                = 1'b0;
        note_bus.valid          = 1'b0;
        note_bus.action         = ACT_WRITE;
        note_bus.entry_index    = '0;
        note_bus.entry_freq     = '0;
        note_bus.entry_duration = '0;
        cfg_bus.valid           = 1'b0;
        cfg_bus.index           = CFG_SONG_LENGTH;
        cfg_bus.data            = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, reset registers (one-note song, 1 MHz tick, shift 3, tempo 1.0).
        // A rest first: it must give the reset held period of zero at full duration.
        send_item(ACT_WRITE, 6'd0, 16'd0, 16'hFFFF);
        send_item(ACT_PLAY, 6'd0, 16'd0, 16'd0);
        // Highest frequency, zero duration.
        send_item(ACT_WRITE, 6'd0, 16'hFFFF, 16'd0);
        send_item(ACT_PLAY, 6'd0, 16'd0, 16'd0);
        // Dead action code with all fields high: no result, no state change.
        send_item(ACT_UNUSED, 6'd63, 16'hFFFF, 16'hFFFF);
        // Lowest tone gives the longest period; a later rest must hold it.
        send_item(ACT_WRITE, 6'd0, 16'd1, 16'd1);
        send_item(ACT_PLAY, 6'd63, 16'hFFFF, 16'hFFFF);
        send_item(ACT_WRITE, 6'd63, 16'd440, 16'd500);
        send_item(ACT_RESTART, 6'd63, 16'hFFFF, 16'hFFFF);
        send_item(ACT_WRITE, 6'd0, 16'd0, 16'd300);
        send_item(ACT_PLAY, 6'd0, 16'd0, 16'd0);
        // Pointer has run past the song end and must wrap back to entry 0.
        send_item(ACT_PLAY, 6'd0, 16'd0, 16'd0);
        send_item(ACT_WRITE, 6'd0, 16'd2000, 16'd1000);
        send_item(ACT_PLAY, 6'd0, 16'd0, 16'd0);
        settle();

        for (int phase = 1; phase <= NUM_PHASES; phase++) begin
            case (phase)
                // Full song, top clock, shift 8, top tempo (saturates long notes).
                1: set_config(7'd64, 27'd100_000_000, 4'd8, 12'd4095, 1'b1);
                // Length 0 acts as 1; a 1 Hz tick underflows nearly every period.
                2: set_config(7'd0, 27'd1, 4'd1, 12'd1, 1'b1);
                // Length past the depth, all-ones clock, oversize shift, zero tempo, hold.
                3: set_config(7'd127, 27'h7FFFFFF, 4'd15, 12'd0, 1'b0);
                // Zero clock rate and zero shift: compare equals period.
                4: set_config(7'd65, 27'd0, 4'd0, 12'd256, 1'b1);
                default: random_config();
            endcase
            // Load every entry once up front, so no play ever reads an unwritten note.
            if (phase == 1) begin
                for (int i = 0; i < NOTE_DEPTH; i++) begin
                    send_item(ACT_WRITE, INDEX_W'(i), rand_freq(), rand_dur());
                end
            end
            // Pressure: plays come back to back; phase 5 also stops the receiver a long stretch.
            burst_mode = (phase == 5 || phase == 8);
            if (phase == 5) begin
                hold_req = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) send_random();
            burst_mode = 1'b0;
            settle();
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### pwm_tone_note_sequencer.f
design/ptns_pkg.sv
design/ptns_if.sv
design/ptns_ctrl.sv
design/ptns_datapath.sv
design/pwm_tone_note_sequencer.sv
sim/ptns_checker.sv
sim/tb_top.sv
